### rtl/lpfe_pkg.sv
// lpfe_pkg: shared widths, codes and controller/datapath link types
// for the led press fade engine; no dependencies, compiled first
package lpfe_pkg;

  localparam int unsigned BUTTONS_DEF = 32;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned BTN_W     = 5;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CD_W      = 13;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned LANES     = COLOR_W / CH_W;
  localparam int unsigned NUM_W     = CH_W + CD_W;
  localparam int unsigned STEP_W    = $clog2(CH_W);

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [KIND_W-1:0] KIND_PRESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_THEME = 2'd2;

  localparam logic REG_COOLDOWN = 1'b0;
  localparam logic REG_DEFAULT  = 1'b1;

  typedef struct packed {
    logic take;
    logic rd;
    logic calc;
    logic mul;
    logic div;
    logic emit;
  } lpfe_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
    logic idx_last;
  } lpfe_sts_t;

endpackage

### rtl/lpfe_if.sv
// lpfe_if: request and result channel interfaces (valid/ready plus payload)
// depends on lpfe_pkg for field widths
interface lpfe_in_if import lpfe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [BTN_W-1:0]     button;
  logic [COLOR_W-1:0]   color_in;
  logic                 theme_present;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, kind, button, color_in, theme_present, elapsed_ms,
                  input ready);
  modport sink (input valid, kind, button, color_in, theme_present, elapsed_ms,
                output ready);
endinterface

interface lpfe_out_if import lpfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BTN_W-1:0]   out_button;
  logic [COLOR_W-1:0] out_color;
  logic               last;

  modport source (output valid, out_button, out_color, last, input ready);
  modport sink (input valid, out_button, out_color, last, output ready);
endinterface

### rtl/led_press_fade_engine_unit.sv
// Press-and-fade LED color engine. A press or theme request is taken from idle and
// leaves the engine idle. A tick request is accepted and then walks the buttons one
// at a time through the single-port state memories in the steps read, calc, multiply
// and emit for a button that reports its default, theme or hit color; a button in
// mid-fade also passes an 8-step restoring divider (all three color channels in
// parallel) between multiply and emit. Emit waits while the result channel stalls.
// No new request is taken until the last result of the tick sits in the output
// register.
// depends on lpfe_pkg, lpfe_if, lpfe_cfg_regs, lpfe_ctrl, lpfe_dpath
module led_press_fade_engine_unit import lpfe_pkg::*; #(
  parameter int unsigned BUTTONS = BUTTONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lpfe_in_if.sink           in_ch,
  lpfe_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CD_W-1:0]    cooldown;
  logic [COLOR_W-1:0] default_color;
  lpfe_cmd_t          cmd;
  lpfe_sts_t          sts;
  logic               in_ready;

  lpfe_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cooldown      (cooldown),
    .default_color (default_color)
  );

  lpfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ready),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  assign in_ch.ready = in_ready;

  lpfe_dpath #(
    .BUTTONS (BUTTONS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cooldown         (cooldown),
    .default_color    (default_color),
    .in_kind          (in_ch.kind),
    .in_button        (in_ch.button),
    .in_color         (in_ch.color_in),
    .in_theme_present (in_ch.theme_present),
    .in_elapsed       (in_ch.elapsed_ms),
    .out_valid        (out_ch.valid),
    .out_button       (out_ch.out_button),
    .out_color        (out_ch.out_color),
    .out_last         (out_ch.last),
    .out_ready        (out_ch.ready)
  );

endmodule

### rtl/lpfe_cfg_regs.sv
// lpfe_cfg_regs: apb register block holding cooldown and default color
// depends on lpfe_pkg
module lpfe_cfg_regs import lpfe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [CD_W-1:0]     cooldown,
  output logic [COLOR_W-1:0]  default_color
);

  logic [CD_W-1:0]    cooldown_r;
  logic [COLOR_W-1:0] default_r;
  logic               reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r <= '0;
      default_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COOLDOWN: cooldown_r <= pwdata[CD_W-1:0];
        REG_DEFAULT:  default_r  <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COOLDOWN: prdata = APB_DW'(cooldown_r);
      REG_DEFAULT:  prdata = APB_DW'(default_r);
      default:      prdata = '0;
    endcase
  end

  assign cooldown      = cooldown_r;
  assign default_color = default_r;

endmodule

### rtl/lpfe_ctrl.sv
// lpfe_ctrl: sequencer that walks the buttons on a tick and steps the divider
// depends on lpfe_pkg; drives lpfe_dpath through lpfe_cmd_t
module lpfe_ctrl import lpfe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  output lpfe_cmd_t         cmd_o,
  input  lpfe_sts_t         sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CALC,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.take = in_valid;
        if (in_valid && in_kind == KIND_TICK) state_nxt = S_RD;
      end
      S_RD: begin
        cmd_o.rd  = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = sts_i.need_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) state_nxt = sts_i.idx_last ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded over a pending one");

  // the final button of a run returns to taking requests
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.emit && sts_i.idx_last) |=> in_ready)
    else $error("run did not end after last button");

  // divider keeps stepping until its final step
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts_i.div_last) |=> (state_r == S_DIV))
    else $error("divider left early");

  // an accepted tick starts the walk at once
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.take && in_kind == KIND_TICK) |=> (state_r == S_RD && !in_ready))
    else $error("tick did not start a run");

endmodule

### rtl/lpfe_dpath.sv
// lpfe_dpath: per-button state memories, timer update, blend multiply,
// restoring divider and output register; depends on lpfe_pkg
module lpfe_dpath import lpfe_pkg::*; #(
  parameter int unsigned BUTTONS = BUTTONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpfe_cmd_t            cmd_i,
  output lpfe_sts_t            sts_o,
  input  logic [CD_W-1:0]      cooldown,
  input  logic [COLOR_W-1:0]   default_color,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [BTN_W-1:0]     in_button,
  input  logic [COLOR_W-1:0]   in_color,
  input  logic                 in_theme_present,
  input  logic [ELAPSED_W-1:0] in_elapsed,
  output logic                 out_valid,
  output logic [BTN_W-1:0]     out_button,
  output logic [COLOR_W-1:0]   out_color,
  output logic                 out_last,
  input  logic                 out_ready
);

  localparam int unsigned IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTONS - 1);

  typedef enum logic [1:0] {
    MODE_DEF,
    MODE_THM,
    MODE_HIT,
    MODE_MIX
  } mode_t;

  // state memories
  logic [CD_W-1:0]    rem_mem [BUTTONS];
  logic [COLOR_W-1:0] hit_mem [BUTTONS];
  logic [COLOR_W-1:0] thm_mem [BUTTONS];
  logic [BUTTONS-1:0] press_vld_r;
  logic [BUTTONS-1:0] thm_vld_r;

  logic [IDX_W-1:0]     idx_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  logic [CD_W-1:0]    rem_q;
  logic [COLOR_W-1:0] hit_q;
  logic [COLOR_W-1:0] thm_q;
  logic               pv_q;
  logic               tv_q;

  logic [CD_W-1:0]    t_r;
  logic [COLOR_W-1:0] hit_r;
  logic [COLOR_W-1:0] thm_r;
  mode_t              mode_r;

  logic [NUM_W-1:0]   num_r [LANES];
  logic [CH_W-1:0]    q_r   [LANES];
  logic [STEP_W-1:0]  step_r;

  logic               out_vld_r;
  logic [BTN_W-1:0]   out_button_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  logic [IDX_W+BTN_W-1:0] btn_ext;
  logic [IDX_W+BTN_W-1:0] idx_ext;
  logic [IDX_W-1:0]       wr_idx;
  logic                   in_range;
  logic                   is_press;
  logic                   is_theme;
  logic                   is_tick;
  logic [ELAPSED_W-1:0]   rem_ext;
  logic [ELAPSED_W-1:0]   rem_diff;
  logic [CD_W-1:0]        t_calc;
  mode_t                  mode_calc;
  logic [CD_W-1:0]        t_inv;
  logic [NUM_W-1:0]       num_mul [LANES];
  logic [NUM_W-1:0]       dsh;
  logic                   ge      [LANES];
  logic [COLOR_W-1:0]     mix_color;
  logic [COLOR_W-1:0]     sel_color;

  assign btn_ext  = (IDX_W + BTN_W)'(in_button);
  assign idx_ext  = (IDX_W + BTN_W)'(idx_r);
  assign wr_idx   = btn_ext[IDX_W-1:0];
  assign in_range = (32'(in_button) < 32'(BUTTONS));
  assign is_press = cmd_i.take && (in_kind == KIND_PRESS) && in_range;
  assign is_theme = cmd_i.take && (in_kind == KIND_THEME) && in_range;
  assign is_tick  = cmd_i.take && (in_kind == KIND_TICK);

  // timer update, saturating at zero; an unpressed button reads as zero
  assign rem_ext  = ELAPSED_W'(rem_q);
  assign rem_diff = rem_ext - elapsed_r;
  assign t_calc   = (pv_q && rem_ext > elapsed_r) ? rem_diff[CD_W-1:0] : '0;

  always_comb begin
    priority if (!tv_q)           mode_calc = MODE_DEF;
    else if (t_calc == '0)        mode_calc = MODE_THM;
    else if (t_calc >= cooldown)  mode_calc = MODE_HIT;
    else                          mode_calc = MODE_MIX;
  end

  assign t_inv = cooldown - t_r;
  assign dsh   = NUM_W'(cooldown) << (STEP_W'(CH_W - 1) - step_r);

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      num_mul[j] = NUM_W'(hit_r[j*CH_W +: CH_W]) * NUM_W'(t_r)
                 + NUM_W'(thm_r[j*CH_W +: CH_W]) * NUM_W'(t_inv);
      ge[j]      = (num_r[j] >= dsh);
      mix_color[j*CH_W +: CH_W] = q_r[j];
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_DEF: sel_color = default_color;
      MODE_THM: sel_color = thm_r;
      MODE_HIT: sel_color = hit_r;
      MODE_MIX: sel_color = mix_color;
      default:  sel_color = default_color;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (is_press) begin
      rem_mem[wr_idx] <= cooldown;
    end else if (cmd_i.calc && pv_q) begin
      rem_mem[idx_r] <= t_calc;
    end
    if (is_press) hit_mem[wr_idx] <= in_color;
    if (is_theme && in_theme_present) thm_mem[wr_idx] <= in_color;
    if (cmd_i.rd) begin
      rem_q <= rem_mem[idx_r];
      hit_q <= hit_mem[idx_r];
      thm_q <= thm_mem[idx_r];
      pv_q  <= press_vld_r[idx_r];
      tv_q  <= thm_vld_r[idx_r];
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (is_tick) elapsed_r <= in_elapsed;
    if (cmd_i.calc) begin
      t_r    <= t_calc;
      hit_r  <= pv_q ? hit_q : '0;
      thm_r  <= thm_q;
      mode_r <= mode_calc;
    end
    for (int j = 0; j < LANES; j++) begin
      if (cmd_i.mul) begin
        num_r[j] <= num_mul[j];
        q_r[j]   <= '0;
      end else if (cmd_i.div) begin
        if (ge[j]) num_r[j] <= num_r[j] - dsh;
        q_r[j] <= {q_r[j][CH_W-2:0], ge[j]};
      end
    end
    if (cmd_i.emit) begin
      out_button_r <= idx_ext[BTN_W-1:0];
      out_color_r  <= sel_color;
      out_last_r   <= (idx_r == IDX_LAST);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_vld_r <= '0;
      thm_vld_r   <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (is_press) press_vld_r[wr_idx] <= 1'b1;
      if (is_theme) thm_vld_r[wr_idx] <= in_theme_present;
      if (is_tick) begin
        idx_r <= '0;
      end else if (cmd_i.emit) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd_i.mul) begin
        step_r <= '0;
      end else if (cmd_i.div) begin
        step_r <= step_r + 1'b1;
      end
      if (cmd_i.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts_o.need_div = (mode_r == MODE_MIX);
  assign sts_o.div_last = (step_r == STEP_W'(CH_W - 1));
  assign sts_o.out_free = !out_vld_r || out_ready;
  assign sts_o.idx_last = (idx_r == IDX_LAST);

  assign out_valid  = out_vld_r;
  assign out_button = out_button_r;
  assign out_color  = out_color_r;
  assign out_last   = out_last_r;

endmodule

### bench/led_press_fade_engine_unit_test.sv
// led_press_fade_engine_unit_test: self-checking bench for the press-and-fade led engine,
// driving requests, ticks and register writes and checking every reported color
// depends on lpfe_pkg, lpfe_if and the led_press_fade_engine_unit rtl
`timescale 1ns / 1ps

module led_press_fade_engine_unit_test import lpfe_pkg::*; ();

  localparam int unsigned NBTN = BUTTONS_DEF;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_COOLDOWN = {REG_COOLDOWN, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_DEFAULT = {REG_DEFAULT, 2'b00};
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 136;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BTN_W-1:0]     button;
    logic [COLOR_W-1:0]   color;
    logic                 present;
    logic [ELAPSED_W-1:0] elapsed;
  } led_req_t;

  typedef struct packed {
    logic [BTN_W-1:0]   button;
    logic [COLOR_W-1:0] color;
    logic               last;
  } led_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  lpfe_in_if  req_ch ();
  lpfe_out_if led_ch ();

  led_press_fade_engine_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (led_ch),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  // predicted engine state
  logic [CD_W-1:0]    cfg_cooldown;
  logic [COLOR_W-1:0] cfg_default;
  logic [CD_W-1:0]    remaining_ms [NBTN];
  logic [COLOR_W-1:0] hit_color [NBTN];
  logic               theme_valid [NBTN];
  logic [COLOR_W-1:0] theme_color [NBTN];

  led_result_t pending_colors [$];
  led_result_t got_color;

  int unsigned errors;
  int unsigned requests_sent;
  int unsigned ticks_sent;
  int unsigned colors_checked;
  int unsigned cfg_writes;
  int unsigned idle_cycles;
  int unsigned hold_len;
  bit          in_gaps_on;
  bit          out_gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [COLOR_W-1:0] fade_color(input logic [COLOR_W-1:0] hit,
                                                    input logic [COLOR_W-1:0] theme,
                                                    input logic [CD_W-1:0] t,
                                                    input logic [CD_W-1:0] c);
    logic [COLOR_W-1:0] mixed;
    int unsigned num;
    mixed = '0;
    if (t == 0) return theme;
    if (t >= c) return hit;
    for (int ch = 0; ch < LANES; ch++) begin
      num = 32'(hit[CH_W*ch +: CH_W]) * 32'(t) + 32'(theme[CH_W*ch +: CH_W]) * 32'(c - t);
      mixed[CH_W*ch +: CH_W] = CH_W'(num / 32'(c));
    end
    return mixed;
  endfunction

  function automatic led_req_t make_req(input logic [KIND_W-1:0] kind,
                                        input logic [BTN_W-1:0] button,
                                        input logic [COLOR_W-1:0] color,
                                        input logic present,
                                        input logic [ELAPSED_W-1:0] elapsed);
    led_req_t r;
    r.kind = kind;
    r.button = button;
    r.color = color;
    r.present = present;
    r.elapsed = elapsed;
    return r;
  endfunction

  task automatic advance_leds(input led_req_t r);
    led_result_t res;
    case (r.kind)
      KIND_PRESS: begin
        remaining_ms[r.button] = cfg_cooldown;
        hit_color[r.button] = r.color;
      end
      KIND_THEME: begin
        theme_valid[r.button] = r.present;
        if (r.present) theme_color[r.button] = r.color;
      end
      KIND_TICK: begin
        for (int i = 0; i < NBTN; i++) begin
          remaining_ms[i] = (remaining_ms[i] > r.elapsed) ?
                            CD_W'(remaining_ms[i] - r.elapsed) : '0;
          res.button = BTN_W'(i);
          res.color = theme_valid[i] ?
                      fade_color(hit_color[i], theme_color[i], remaining_ms[i], cfg_cooldown) :
                      cfg_default;
          res.last = (i == NBTN - 1);
          pending_colors.push_back(res);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input led_req_t r);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= r.kind;
    req_ch.button <= r.button;
    req_ch.color_in <= r.color;
    req_ch.theme_present <= r.present;
    req_ch.elapsed_ms <= r.elapsed;
    do @(posedge clk); while (!req_ch.ready);
    advance_leds(r);
    requests_sent++;
    if (r.kind == KIND_TICK) ticks_sent++;
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write then read back one register
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] stored;
    stored = (addr == ADDR_COOLDOWN) ? APB_DW'(value[CD_W-1:0]) : APB_DW'(value[COLOR_W-1:0]);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_COOLDOWN) cfg_cooldown = value[CD_W-1:0];
    else cfg_default = value[COLOR_W-1:0];
    cfg_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== stored) begin
      errors++;
      $error("prdata at %0d: expected %h, got %h", addr, stored, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_colors();
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd0));
  endtask

  task automatic test_fade_extremes();
    wait_idle();
    write_reg(ADDR_COOLDOWN, 32'd1000);
    write_reg(ADDR_DEFAULT, 32'h123456);
    send_request(make_req(KIND_THEME, 5'd0, 24'hFFFFFF, 1'b1, 16'hFFFF));
    send_request(make_req(KIND_THEME, 5'd31, 24'h000000, 1'b1, 16'h0));
    send_request(make_req(KIND_PRESS, 5'd0, 24'h000000, 1'b1, 16'hFFFF));
    send_request(make_req(KIND_PRESS, 5'd31, 24'hFFFFFF, 1'b0, 16'h0));
    send_request(make_req(KIND_TICK, 5'd31, 24'hFFFFFF, 1'b1, 16'd0));
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd250));
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd749));
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'hFFFF));
    send_request(make_req(KIND_SPARE, 5'd31, 24'hFFFFFF, 1'b1, 16'hFFFF));
  endtask

  task automatic test_theme_clear();
    send_request(make_req(KIND_THEME, 5'd0, 24'hABCDEF, 1'b0, 16'd0));
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd0));
    send_request(make_req(KIND_THEME, 5'd0, 24'h0F0F0F, 1'b1, 16'd0));
    send_request(make_req(KIND_PRESS, 5'd0, 24'hF0F0F0, 1'b0, 16'd0));
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd1));
  endtask

  task automatic test_zero_cooldown();
    wait_idle();
    write_reg(ADDR_COOLDOWN, 32'd0);
    write_reg(ADDR_DEFAULT, 32'hFFFFFF);
    send_request(make_req(KIND_THEME, 5'd3, 24'h00FF00, 1'b1, 16'd0));
    send_request(make_req(KIND_PRESS, 5'd3, 24'hFF0000, 1'b0, 16'd0));
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd0));
  endtask

  task automatic test_cooldown_lowered();
    wait_idle();
    write_reg(ADDR_COOLDOWN, 32'd5000);
    send_request(make_req(KIND_THEME, 5'd7, 24'h102030, 1'b1, 16'd0));
    send_request(make_req(KIND_PRESS, 5'd7, 24'hC0B0A0, 1'b0, 16'd0));
    wait_idle();
    write_reg(ADDR_COOLDOWN, 32'd100);
    write_reg(ADDR_DEFAULT, 32'd0);
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd10));
  endtask

  // results held back while more requests queue up behind the tick
  task automatic test_backpressure();
    wait_idle();
    write_reg(ADDR_COOLDOWN, 32'd400);
    hold_len = HOLD_CYCLES;
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd3));
    send_request(make_req(KIND_PRESS, 5'($urandom), 24'($urandom), 1'b1, 16'd0));
    send_request(make_req(KIND_THEME, 5'($urandom), 24'($urandom), 1'b1, 16'd0));
    send_request(make_req(KIND_TICK, 5'd0, 24'h0, 1'b0, 16'd20));
  endtask

  task automatic test_random_traffic();
    led_req_t r;
    int unsigned pick;
    int unsigned span;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      in_gaps_on = (phase == 0 || phase == 2);
      out_gaps_on = (phase == 0 || phase == 3);
      case (phase)
        0: write_reg(ADDR_COOLDOWN, $urandom_range(1, 5000));
        1: write_reg(ADDR_COOLDOWN, $urandom_range(1, 40));
        2: write_reg(ADDR_COOLDOWN, 32'd5000);
        default: write_reg(ADDR_COOLDOWN, $urandom_range(200, 3000));
      endcase
      write_reg(ADDR_DEFAULT, $urandom & 32'hFFFFFF);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        r = make_req(KIND_SPARE, 5'($urandom), 24'($urandom), 1'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          r.kind = KIND_PRESS;
        end else if (pick < 62) begin
          r.kind = KIND_THEME;
          r.present = ($urandom_range(0, 99) < 85);
        end else if (pick < 96) begin
          r.kind = KIND_TICK;
          span = $urandom_range(0, 99);
          if (span < 60) r.elapsed = 16'($urandom_range(0, cfg_cooldown / 8 + 1));
          else if (span < 85) r.elapsed = 16'($urandom_range(0, cfg_cooldown + 16));
        end
        send_request(r);
      end
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned n;
    led_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = hold_len + (out_gaps_on ? $urandom_range(0, 11) : 0);
      hold_len = 0;
      if (n > 0) begin
        led_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      led_ch.ready <= 1'b1;
      do @(posedge clk); while (!led_ch.valid && hold_len == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && led_ch.valid && led_ch.ready) begin
      if (pending_colors.size() == 0) begin
        errors++;
        $error("unexpected result: button %0d color %h last %b",
               led_ch.out_button, led_ch.out_color, led_ch.last);
      end else begin
        got_color = pending_colors.pop_front();
        colors_checked++;
        if (led_ch.out_button !== got_color.button) begin
          errors++;
          $error("out_button: expected %0d, got %0d", got_color.button, led_ch.out_button);
        end
        if (led_ch.out_color !== got_color.color) begin
          errors++;
          $error("out_color: expected %h, got %h", got_color.color, led_ch.out_color);
        end
        if (led_ch.last !== got_color.last) begin
          errors++;
          $error("last: expected %b, got %b", got_color.last, led_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (led_ch.valid && led_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("led_press_fade_engine_unit_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    requests_sent = 0;
    ticks_sent = 0;
    colors_checked = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    hold_len = 0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    cfg_cooldown = '0;
    cfg_default = '0;
    for (int i = 0; i < NBTN; i++) begin
      remaining_ms[i] = '0;
      hit_color[i] = '0;
      theme_valid[i] = 1'b0;
      theme_color[i] = '0;
    end
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_PRESS;
    req_ch.button <= '0;
    req_ch.color_in <= '0;
    req_ch.theme_present <= 1'b0;
    req_ch.elapsed_ms <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_colors();
    test_fade_extremes();
    test_theme_clear();
    test_zero_cooldown();
    test_cooldown_lowered();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d requests (%0d ticks) over %0d register writes",
             requests_sent, ticks_sent, cfg_writes);
    $display("checked %0d led colors, with idle and stall gaps and one long hold-off",
             colors_checked);
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("led_press_fade_engine_unit_test passed");
    end else begin
      $display("led_press_fade_engine_unit_test failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/lpfe_pkg.sv
rtl/lpfe_if.sv
rtl/lpfe_cfg_regs.sv
rtl/lpfe_ctrl.sv
rtl/lpfe_dpath.sv
rtl/led_press_fade_engine_unit.sv
bench/led_press_fade_engine_unit_test.sv
